// ===== design/ump_text_message_segmenter_assert.svh =====
// ----------------------------------------------------------------------------
// ump text message segmenter assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef UMP_TEXT_MESSAGE_SEGMENTER_ASSERT_SVH
`define UMP_TEXT_MESSAGE_SEGMENTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define UMP_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("ump segmenter check failed");
// next-cycle implication
`define UMP_ASSERT_NXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("ump segmenter check failed");
`else
`define UMP_ASSERT_IMP(lbl, cond, prop)
`define UMP_ASSERT_NXT(lbl, cond, prop)
`endif
`endif

// ===== design/ump_seg_pkg.sv =====
// ----------------------------------------------------------------------------
// ump_seg_pkg
// shared types and constants of the ump text message segmenter
// ----------------------------------------------------------------------------
package ump_seg_pkg;

	localparam int CHUNK_CHARS = 14;
	localparam logic [3:0] CHUNK_FULL = 4'd14;
	localparam logic [6:0] NAME_LIMIT = 7'd98;
	localparam logic [6:0] ID_LIMIT = 7'd42;
	localparam logic [7:0] STATUS_NAME = 8'h03;
	localparam logic [7:0] STATUS_ID = 8'h04;
	localparam logic [7:0] HDR_BASE = 8'hF0;

	typedef enum logic [1:0] {
		FMT_COMPLETE = 2'd0,
		FMT_START    = 2'd1,
		FMT_CONTINUE = 2'd2,
		FMT_END      = 2'd3
	} fmt_t;

	typedef logic [CHUNK_CHARS-1:0][7:0] chunk_t;

	// input request
	typedef struct packed {
		logic       func;
		logic [7:0] char_byte;
		logic       last_char;
	} char_item_t;

	// output request
	typedef struct packed {
		logic [63:0] packet_high;
		logic [63:0] packet_low;
		logic        end_of_run;
		logic        overflow;
	} pkt_item_t;

	// work handed from front to back: one packet, optionally a second
	// one-character end packet (split)
	typedef struct packed {
		chunk_t     chunk;
		logic [3:0] fill;
		fmt_t       fmt;
		logic       kind;
		logic       eor;
		logic       ovf;
		logic       split;
		logic [7:0] ch;
	} seg_entry_t;

	typedef struct packed {
		logic [3:0] fill;
		logic [6:0] length;
	} front_stat_t;

	typedef struct packed {
		logic split_phase;
	} back_stat_t;

endpackage

// ===== design/ump_seg_front.sv =====
// ----------------------------------------------------------------------------
// ump_seg_front
// accepts characters, tracks chunk and text state, posts packet work
// ----------------------------------------------------------------------------
module ump_seg_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     char_valid,
	output logic                     char_ready,
	input  ump_seg_pkg::char_item_t  char_item,
	input  logic                     q_full,
	output logic                     q_push,
	output ump_seg_pkg::seg_entry_t  q_data,
	output ump_seg_pkg::front_stat_t stat
);
	import ump_seg_pkg::*;

	chunk_t     chunk_q;
	chunk_t     chunk_next;
	logic [3:0] fill_q;
	logic [6:0] len_q;
	logic       sent_q;
	logic       kind_q;
	logic       dropped_q;

	logic       accept;
	logic       kind_eff;
	logic [6:0] limit;
	logic       store_ok;
	logic       full;
	logic       flush;

	assign char_ready = !q_full;
	assign accept     = char_valid && char_ready;
	assign kind_eff   = (len_q == 7'd0 && fill_q == 4'd0 && !sent_q) ? char_item.func : kind_q;
	assign limit      = kind_eff ? ID_LIMIT : NAME_LIMIT;
	assign store_ok   = len_q < limit;
	assign full       = fill_q == CHUNK_FULL;
	assign flush      = store_ok && full;
	assign q_push     = accept && (flush || char_item.last_char);
	assign stat       = '{fill: fill_q, length: len_q};

	always_comb begin
		for (int i = 0; i < CHUNK_CHARS; i++) begin
			chunk_next[i] = (store_ok && !full && fill_q == 4'(i)) ? char_item.char_byte
				: chunk_q[i];
		end
	end

	always_comb begin
		q_data.kind = kind_eff;
		q_data.ch   = char_item.char_byte;
		if (flush) begin
			// held full chunk leaves, new char may close the text after it
			q_data.chunk = chunk_q;
			q_data.fill  = CHUNK_FULL;
			q_data.fmt   = sent_q ? FMT_CONTINUE : FMT_START;
			q_data.eor   = !char_item.last_char;
			q_data.ovf   = 1'b0;
			q_data.split = char_item.last_char;
		end else begin
			q_data.chunk = chunk_next;
			q_data.fill  = store_ok ? fill_q + 4'd1 : fill_q;
			q_data.fmt   = sent_q ? FMT_END : FMT_COMPLETE;
			q_data.eor   = 1'b1;
			q_data.ovf   = dropped_q || !store_ok;
			q_data.split = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_ok) begin
			if (full) begin
				chunk_q[0] <= char_item.char_byte;
			end else begin
				chunk_q <= chunk_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 4'd0;
			len_q     <= 7'd0;
			sent_q    <= 1'b0;
			kind_q    <= 1'b0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			kind_q <= kind_eff;
			if (char_item.last_char) begin
				fill_q    <= 4'd0;
				len_q     <= 7'd0;
				sent_q    <= 1'b0;
				dropped_q <= 1'b0;
			end else if (store_ok) begin
				len_q <= len_q + 7'd1;
				if (full) begin
					fill_q <= 4'd1;
					sent_q <= 1'b1;
				end else begin
					fill_q <= fill_q + 4'd1;
				end
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/ump_seg_queue.sv =====
// ----------------------------------------------------------------------------
// ump_seg_queue
// small register fifo of packet work between front and back
// ----------------------------------------------------------------------------
module ump_seg_queue #(
	parameter int DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  ump_seg_pkg::seg_entry_t push_data,
	input  logic                    pop,
	output ump_seg_pkg::seg_entry_t head,
	output logic                    empty,
	output logic                    full
);
	import ump_seg_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	seg_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = count_q == CW'(0);
	assign full  = count_q == CW'(DEPTH);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/ump_seg_back.sv =====
// ----------------------------------------------------------------------------
// ump_seg_back
// formats queued work into ump packets behind an output register
// ----------------------------------------------------------------------------
module ump_seg_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ump_seg_pkg::seg_entry_t head,
	input  logic                    q_empty,
	output logic                    pop,
	output logic                    pkt_valid,
	input  logic                    pkt_ready,
	output ump_seg_pkg::pkt_item_t  pkt_item,
	output ump_seg_pkg::back_stat_t stat
);
	import ump_seg_pkg::*;

	function automatic pkt_item_t make_packet(logic kind, fmt_t fmt, chunk_t chunk,
		logic [3:0] fill, logic eor, logic ovf);
		logic [15:0][7:0] bytes;
		pkt_item_t        p;
		bytes[15] = HDR_BASE | {4'd0, fmt, 2'd0};
		bytes[14] = kind ? STATUS_ID : STATUS_NAME;
		for (int i = 0; i < CHUNK_CHARS; i++) begin
			bytes[13-i] = (4'(i) < fill) ? chunk[i] : 8'd0;
		end
		p.packet_high = bytes[15:8];
		p.packet_low  = bytes[7:0];
		p.end_of_run  = eor;
		p.overflow    = ovf;
		return p;
	endfunction

	logic      valid_q;
	logic      phase_q;
	logic      load;
	chunk_t    tail_chunk;
	pkt_item_t next_item;

	assign load       = !valid_q || pkt_ready;
	assign pop        = load && !q_empty && (phase_q || !head.split);
	assign pkt_valid  = valid_q;
	assign stat       = '{split_phase: phase_q};

	always_comb begin
		tail_chunk    = '0;
		tail_chunk[0] = head.ch;
		if (phase_q) begin
			// one-character end packet after a flushed full chunk
			next_item = make_packet(head.kind, FMT_END, tail_chunk, 4'd1, 1'b1, 1'b0);
		end else begin
			next_item = make_packet(head.kind, head.fmt, head.chunk, head.fill,
				head.eor, head.ovf);
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			pkt_item <= next_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (!q_empty) begin
				phase_q <= !phase_q && head.split;
			end
		end
	end

endmodule

// ===== design/ump_text_message_segmenter.sv =====
// ----------------------------------------------------------------------------
// ump_text_message_segmenter
// packs text characters into 128-bit ump stream packets (endpoint name
// and product instance id notifications)
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  char    | in        | char_valid/char_ready | char_item (func, char_byte, last_char)
//  pkt     | out       | pkt_valid/pkt_ready   | pkt_item (packet_high/low, flags)
//
// one character accepted per cycle while the queue is not full; packets leave
// one per cycle from the output register while pkt_ready is high, so an item that
// flushes a full chunk and also ends the text yields two packets in turn
// the queue of QUEUE_DEPTH entries lets the front keep accepting while the
// output is stalled; char_ready drops only when the queue is full
// arst_n clears all control state at once, no clearing pass follows
// ----------------------------------------------------------------------------
`include "ump_text_message_segmenter_assert.svh"

module ump_text_message_segmenter #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_ready,
	input  ump_seg_pkg::char_item_t char_item,
	output logic                   pkt_valid,
	input  logic                   pkt_ready,
	output ump_seg_pkg::pkt_item_t  pkt_item
);
	import ump_seg_pkg::*;

	// front to queue
	logic        q_push;
	seg_entry_t  q_wdata;
	// queue to back
	seg_entry_t  q_head;
	logic        q_pop;
	logic        q_empty;
	logic        q_full;
	// status for checks
	front_stat_t front_stat;
	back_stat_t  back_stat;

	// front: classify the character, update chunk state, post packet work
	ump_seg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata),
		.stat       (front_stat)
	);

	// decoupling queue
	ump_seg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// back: format packets, hold them in the output register
	ump_seg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.pop       (q_pop),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt_item  (pkt_item),
		.stat      (back_stat)
	);

	// no work is ever posted into a full queue
	`UMP_ASSERT_IMP(a_no_push_full, q_push, !q_full)
	// the second half of a split entry always has its entry still queued
	`UMP_ASSERT_IMP(a_split_has_head, back_stat.split_phase, !q_empty)
	// chunk fill never passes one packet's worth of characters
	`UMP_ASSERT_IMP(a_fill_bound, 1'b1, front_stat.fill <= CHUNK_FULL)
	// the final character always leaves the text state cleared
	`UMP_ASSERT_NXT(a_last_clears, char_valid && char_ready && char_item.last_char,
		front_stat.fill == 4'd0 && front_stat.length == 7'd0)

endmodule

// ===== test/ump_text_message_segmenter_tb.sv =====
// ----------------------------------------------------------------------------
// ump_text_message_segmenter_tb
// Self-checking testbench for the ump text message segmenter. An initial
// block queues whole texts of characters: a short directed set first, then
// random texts with lengths around the chunk size and the two length
// limits. A clocked driver sends them as char requests and a clocked
// monitor takes pkt requests. Each accepted character runs through a
// local packing model, and every packet out is compared with the oldest
// packet that this model expects. The run uses four idling mixes, and it
// drains all expected packets between them.
// ----------------------------------------------------------------------------
module ump_text_message_segmenter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ump_seg_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;	// cycles with no request moving on either side
	localparam int DRAIN_CYCLES   = 20;		// quiet cycles after the last packet
	localparam int PHASE_CHARS    = 280;	// least count of random characters per phase
	localparam int MAX_REPORTS    = 10;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_ready;
	char_item_t char_item  = '0;
	logic       pkt_valid;
	logic       pkt_ready  = 1'b0;
	pkt_item_t  pkt_item;

	// character requests waiting for the driver, packets waiting for the monitor
	char_item_t pending_chars[$];
	pkt_item_t  expected_packets[$];
	pkt_item_t  oldest_packet;

	// idling mix of the current phase, in percent of cycles
	int send_idle_pct = 0;
	int stall_pct     = 0;

	int mismatches    = 0;
	int chars_sent    = 0;
	int texts_sent    = 0;
	int packets_seen  = 0;
	int overflow_seen = 0;
	int quiet_cycles  = 0;

	// packing model state: the chunk being filled and the text bookkeeping
	logic [7:0] held_chars [CHUNK_CHARS];
	logic [3:0] held_fill    = '0;
	logic [6:0] text_len     = '0;
	logic       start_sent   = 1'b0;
	logic       text_kind    = 1'b0;
	logic       text_dropped = 1'b0;

	ump_text_message_segmenter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.pkt_valid  (pkt_valid),
		.pkt_ready  (pkt_ready),
		.pkt_item   (pkt_item)
	);

	always #6 clk = ~clk;

	// one 128-bit packet from the held characters, unused positions zero
	function automatic pkt_item_t build_packet(fmt_t fmt, logic eor, logic ovf);
		logic [127:0] bytes;
		pkt_item_t    pkt;
		bytes = '0;
		bytes[127:120] = HDR_BASE | {4'b0000, fmt, 2'b00};
		bytes[119:112] = text_kind ? STATUS_ID : STATUS_NAME;
		for (int i = 0; i < CHUNK_CHARS; i++) begin
			if (i < held_fill)
				bytes[111 - 8 * i -: 8] = held_chars[i];
		end
		pkt.packet_high = bytes[127:64];
		pkt.packet_low  = bytes[63:0];
		pkt.end_of_run  = eor;
		pkt.overflow    = ovf;
		return pkt;
	endfunction

	// packets caused by one accepted character
	function automatic void predict_packets(char_item_t c);
		logic [6:0] limit;
		// only the first character of a text picks the message kind
		if (text_len == 0 && held_fill == 0 && !start_sent)
			text_kind = c.func;
		limit = text_kind ? ID_LIMIT : NAME_LIMIT;
		if (text_len < limit) begin
			// a full chunk leaves only once another character shows up
			if (held_fill == CHUNK_FULL) begin
				expected_packets.push_back(build_packet(start_sent ? FMT_CONTINUE : FMT_START,
					!c.last_char, 1'b0));
				start_sent = 1'b1;
				held_fill  = '0;
			end
			held_chars[held_fill] = c.char_byte;
			held_fill++;
			text_len++;
		end else begin
			// past the limit: character dropped, flagged on the final packet
			text_dropped = 1'b1;
		end
		if (c.last_char) begin
			expected_packets.push_back(build_packet(start_sent ? FMT_END : FMT_COMPLETE,
				1'b1, text_dropped));
			held_fill    = '0;
			text_len     = '0;
			start_sent   = 1'b0;
			text_dropped = 1'b0;
		end
	endfunction

	function automatic void queue_char(logic func, logic [7:0] char_byte, logic last_char);
		char_item_t c;
		c.func      = func;
		c.char_byte = char_byte;
		c.last_char = last_char;
		pending_chars.push_back(c);
	endfunction

	// random bytes, zero included; func flips at random after the first character
	function automatic void queue_text(int len, logic func);
		for (int i = 0; i < len; i++)
			queue_char((i == 0) ? func : logic'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), i == len - 1);
	endfunction

	// mostly short texts, some around the chunk edges and the two limits
	function automatic int pick_length();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom_range(1, 14);
			5, 6: return $urandom_range(15, 42);
			7: return $urandom_range(0, 1) ? $urandom_range(13, 16) : $urandom_range(27, 29);
			8: return $urandom_range(40, 45);
			default: return $urandom_range(90, 110);
		endcase
	endfunction

	function automatic void queue_random_texts(int target);
		int n;
		int len;
		n = 0;
		while (n < target) begin
			len = pick_length();
			queue_text(len, logic'($urandom_range(0, 1)));
			n += len;
		end
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	// hold the sender until every queued character is in and every packet is out
	task automatic run_phase(int send_pct, int stall_in);
		send_idle_pct = send_pct;
		stall_pct     = stall_in;
		while (pending_chars.size() != 0 || char_valid || expected_packets.size() != 0)
			@(negedge clk);
	endtask

	// driver: a request stays up, unchanged, until the block takes it
	always @(posedge clk) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else begin
			if (char_valid && char_ready) begin
				predict_packets(char_item);
				chars_sent++;
				if (char_item.last_char)
					texts_sent++;
			end
			if (!char_valid || char_ready) begin
				if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					char_valid <= 1'b1;
					char_item  <= pending_chars.pop_front();
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, each packet checked against the oldest expectation
	always @(posedge clk) begin
		if (!arst_n) begin
			pkt_ready <= 1'b0;
		end else begin
			if (pkt_valid && pkt_ready) begin
				packets_seen++;
				if (pkt_item.overflow === 1'b1)
					overflow_seen++;
				if (expected_packets.size() == 0) begin
					note_mismatch($sformatf("packet with none expected: high %h low %h eor %b ovf %b",
						pkt_item.packet_high, pkt_item.packet_low,
						pkt_item.end_of_run, pkt_item.overflow));
				end else begin
					oldest_packet = expected_packets.pop_front();
					if (pkt_item.packet_high !== oldest_packet.packet_high ||
						pkt_item.packet_low  !== oldest_packet.packet_low  ||
						pkt_item.end_of_run  !== oldest_packet.end_of_run  ||
						pkt_item.overflow    !== oldest_packet.overflow) begin
						note_mismatch($sformatf(
							"expected high %h low %h eor %b ovf %b, got high %h low %h eor %b ovf %b",
							oldest_packet.packet_high, oldest_packet.packet_low,
							oldest_packet.end_of_run, oldest_packet.overflow,
							pkt_item.packet_high, pkt_item.packet_low,
							pkt_item.end_of_run, pkt_item.overflow));
					end
				end
			end
			pkt_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// watchdog: too long with no request moving ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && char_ready) || (pkt_valid && pkt_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles, %0d packets still expected",
					WATCHDOG_LIMIT, expected_packets.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: byte extremes as one-character texts under both kinds,
		// then a 15-character text whose last character flushes the full
		// chunk and closes the text in the same request, func toggling throughout
		@(negedge clk);
		queue_char(1'b0, 8'hFF, 1'b1);
		queue_char(1'b1, 8'h00, 1'b1);
		queue_char(1'b0, 8'h01, 1'b1);
		queue_char(1'b1, 8'h80, 1'b1);
		queue_char(1'b0, 8'h7F, 1'b1);
		for (int i = 0; i < 15; i++)
			queue_char(i[0] ? 1'b0 : 1'b1, 8'h41 + 8'(i), i == 14);
		run_phase(0, 0);

		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			if (phase == 0) begin
				// lengths on the chunk edges and on both limits, past them too
				queue_text(14, 1'b1);
				queue_text(28, 1'b1);
				queue_text(42, 1'b1);
				queue_text(43, 1'b1);
				queue_text(56, 1'b1);
				queue_text(98, 1'b0);
				queue_text(99, 1'b0);
				queue_text(112, 1'b0);
			end
			queue_random_texts(PHASE_CHARS);
			case (phase)
				0: run_phase(0, 0);
				1: run_phase(81, 0);
				2: run_phase(0, 81);
				default: run_phase(26, 26);
			endcase
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d texts of %0d characters in total, across four idling mixes",
			texts_sent, chars_sent);
		$display("checked %0d packets, %0d of them with overflow, %0d mismatches",
			packets_seen, overflow_seen, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
